// ----- rtl/tcbc_pkg.sv -----
// Shared types and constants for the thermal-capped backlight controller.
// Used by tcbc_cfg, tcbc_ctrl, tcbc_dp and the top level. No dependencies.
`default_nettype none

package tcbc_pkg;

  // Field widths
  localparam int MODE_W = 2;
  localparam int VAL_W  = 8;
  localparam int STEP_W = 4;
  localparam int PROD_W = 2 * VAL_W;
  localparam int IN_DATA_W  = 16;
  localparam int OUT_DATA_W = 24;

  // Cap table depth default and reset values
  localparam int STEP_COUNT_DEF = 12;
  localparam logic [VAL_W-1:0]  CAP_RESET  = 8'd175;
  localparam logic [VAL_W-1:0]  FULL_RESET = 8'd255;
  localparam logic [VAL_W-1:0]  LEVEL_MAX  = 8'd255;
  localparam logic [STEP_W-1:0] TOP_RESET  = 4'd12;

  // Serial divider: one quotient bit per cycle
  localparam int DIV_STEPS = PROD_W;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS);

  // APB register map (word index)
  localparam int CFG_ADDR_W = 4;
  typedef enum logic [1:0] {
    REG_PWM_SELECT  = 2'd0,
    REG_LIMIT_LEVEL = 2'd1,
    REG_FULL_SCALE  = 2'd2,
    REG_TOP_STEP    = 2'd3
  } reg_idx_t;

  // Request kinds carried on in_tuser
  typedef enum logic [MODE_W-1:0] {
    MODE_USER  = 2'd0,
    MODE_STEP  = 2'd1,
    MODE_CAP   = 2'd2,
    MODE_QUERY = 2'd3
  } mode_t;

  typedef struct packed {
    logic              pwm_select;
    logic [VAL_W-1:0]  limit_level;
    logic [VAL_W-1:0]  full_scale;
    logic [STEP_W-1:0] top_step;
  } cfg_t;

  // Controller states, one-hot
  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_EXEC = 5'b00010,
    ST_MUL  = 5'b00100,
    ST_DIV  = 5'b01000,
    ST_DONE = 5'b10000
  } state_t;

  // Controller -> datapath commands
  typedef struct packed {
    logic load_item;
    logic exec;
    logic mul;
    logic div_step;
    logic out_load;
  } cmd_t;

  // Datapath -> controller status
  typedef struct packed {
    logic need_div;
    logic div_last;
  } stat_t;

endpackage

`default_nettype wire

// ----- rtl/tcbc_cfg.sv -----
// APB-style configuration registers for the backlight controller.
// Depends on tcbc_pkg (cfg_t, register indexes, reset values).
`default_nettype none

module tcbc_cfg
  import tcbc_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [CFG_ADDR_W-1:0] paddr,
  input  wire logic [31:0]           pwdata,
  output logic      [31:0]           prdata,
  output logic                       pready,
  output cfg_t                       cfg
);

  cfg_t     cfg_r;
  reg_idx_t widx;
  logic     wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign widx   = reg_idx_t'(paddr[3:2]);
  assign cfg    = cfg_r;

  // Register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.pwm_select  <= 1'b0;
      cfg_r.limit_level <= '0;
      cfg_r.full_scale  <= FULL_RESET;
      cfg_r.top_step    <= TOP_RESET;
    end else if (wr_en) begin
      unique case (widx)
        REG_PWM_SELECT:  cfg_r.pwm_select  <= pwdata[0];
        REG_LIMIT_LEVEL: cfg_r.limit_level <= pwdata[VAL_W-1:0];
        REG_FULL_SCALE:  cfg_r.full_scale  <= pwdata[VAL_W-1:0];
        REG_TOP_STEP:    cfg_r.top_step    <= pwdata[STEP_W-1:0];
        default: ;
      endcase
    end
  end

  // Read back
  always_comb begin
    prdata = '0;
    unique case (widx)
      REG_PWM_SELECT:  prdata = {31'd0, cfg_r.pwm_select};
      REG_LIMIT_LEVEL: prdata = {24'd0, cfg_r.limit_level};
      REG_FULL_SCALE:  prdata = {24'd0, cfg_r.full_scale};
      REG_TOP_STEP:    prdata = {28'd0, cfg_r.top_step};
      default:         prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

// ----- rtl/tcbc_ctrl.sv -----
// Sequencing FSM for the backlight controller: handshakes and command strobes.
// Depends on tcbc_pkg (state_t, cmd_t, stat_t).
`default_nettype none

module tcbc_ctrl
  import tcbc_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  in_tvalid,
  output logic       in_tready,
  output logic       out_tvalid,
  input  wire logic  out_tready,
  input  wire stat_t stat,
  output cmd_t       cmd
);

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = out_valid_r;

  // Command strobes
  always_comb begin
    cmd.load_item = (state_r == ST_IDLE) && in_tvalid;
    cmd.exec      = (state_r == ST_EXEC);
    cmd.mul       = (state_r == ST_MUL);
    cmd.div_step  = (state_r == ST_DIV);
    cmd.out_load  = (state_r == ST_DONE) && (!out_valid_r || out_tready);
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (in_tvalid)     state_nxt = ST_EXEC;
      ST_EXEC: state_nxt = stat.need_div ? ST_MUL : ST_DONE;
      ST_MUL:  state_nxt = ST_DIV;
      ST_DIV:  if (stat.div_last) state_nxt = ST_DONE;
      ST_DONE: if (cmd.out_load)  state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Output register occupancy
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.out_load)     out_valid_nxt = 1'b1;
    else if (out_tready)  out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/tcbc_dp.sv -----
// Datapath: brightness state, cap table, 8x8 scaling multiply, serial divider
// and the result register. Depends on tcbc_pkg; driven by tcbc_ctrl commands.
`default_nettype none

module tcbc_dp
  import tcbc_pkg::*;
#(
  parameter int STEP_COUNT = STEP_COUNT_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire cfg_t                  cfg,
  input  wire logic [MODE_W-1:0]     in_mode,
  input  wire logic [VAL_W-1:0]      in_value,
  input  wire logic [STEP_W-1:0]     in_index,
  input  wire cmd_t                  cmd,
  output stat_t                      stat,
  output logic      [OUT_DATA_W-1:0] out_data
);

  localparam int AW = (STEP_COUNT > 1) ? $clog2(STEP_COUNT) : 1;
  localparam logic [STEP_W-1:0] SC = STEP_W'(STEP_COUNT);

  // Latched request
  mode_t             mode_r;
  logic [VAL_W-1:0]  value_r;
  logic [STEP_W-1:0] index_r;

  // Controller state
  logic [VAL_W-1:0]  applied_r, applied_nxt;
  logic [VAL_W-1:0]  shown_r, shown_nxt;
  logic [VAL_W-1:0]  ureq_r, ureq_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic [VAL_W-1:0]  cap_r [STEP_COUNT];

  // Per-request results
  logic              res_valid_r, res_up_r, res_down_r, status_r;
  logic [VAL_W-1:0]  res_drive_r, res_drive_nxt;
  logic [VAL_W-1:0]  lvl_r;
  logic [OUT_DATA_W-1:0] out_data_r;

  // Divider
  logic [VAL_W-1:0]     rem_r, den_r;
  logic [PROD_W-1:0]    quo_r;
  logic [DIV_CNT_W-1:0] cnt_r;

  // Execute-cycle decode
  logic [STEP_W-1:0] top_c, s_clamp, sel_step, sel_m1;
  logic [VAL_W-1:0]  cap_rd, ureq_eff, lvl;
  logic              do_apply, fire, scale_en, cap_wr, status_nxt;

  always_comb begin
    top_c    = (cfg.top_step > SC) ? SC : cfg.top_step;
    s_clamp  = (index_r > top_c) ? top_c : index_r;
    sel_step = (mode_r == MODE_USER) ? step_r : s_clamp;
    sel_m1   = sel_step - 1'b1;
    cap_rd   = CAP_RESET;
    if (sel_step != '0 && sel_step <= SC) cap_rd = cap_r[sel_m1[AW-1:0]];
    ureq_eff = (step_r == '0) ? applied_r : ureq_r;
  end

  always_comb begin
    applied_nxt = applied_r;
    shown_nxt   = shown_r;
    ureq_nxt    = ureq_r;
    step_nxt    = step_r;
    do_apply    = 1'b0;
    lvl         = value_r;
    cap_wr      = 1'b0;
    status_nxt  = 1'b0;
    case (mode_r)
      MODE_USER: begin
        ureq_nxt = value_r;
        if (step_r != '0 && step_r <= SC && value_r > cap_rd) begin
          shown_nxt = cap_rd;
        end else begin
          do_apply = 1'b1;
          lvl      = value_r;
        end
      end
      MODE_STEP: begin
        ureq_nxt = ureq_eff;
        if (step_r != index_r) begin
          step_nxt = s_clamp;
          if (s_clamp == '0) begin
            do_apply = 1'b1;
            lvl      = ureq_eff;
          end else if (cap_rd <= ureq_eff) begin
            do_apply = 1'b1;
            lvl      = cap_rd;
          end
        end
      end
      MODE_CAP: begin
        if (index_r >= SC) status_nxt = 1'b1;
        else               cap_wr     = 1'b1;
      end
      default: ;
    endcase
    // Applying an unchanged level does nothing
    fire     = do_apply && (applied_r != lvl);
    scale_en = fire && !cfg.pwm_select && (cfg.limit_level != '0);
    if (fire) begin
      applied_nxt = lvl;
      shown_nxt   = lvl;
    end
  end

  assign stat.need_div = scale_en;
  assign stat.div_last = (cnt_r == DIV_CNT_W'(DIV_STEPS - 1));

  // Restoring division step: one quotient bit per cycle
  logic [VAL_W:0]    shifted, diff;
  logic              ge;
  logic [PROD_W-1:0] quo_nxt;

  always_comb begin
    shifted = {rem_r, quo_r[PROD_W-1]};
    diff    = shifted - {1'b0, den_r};
    ge      = (shifted >= {1'b0, den_r});
    quo_nxt = {quo_r[PROD_W-2:0], ge};
    // Saturate quotients above the level range
    res_drive_nxt = (|quo_nxt[PROD_W-1:VAL_W]) ? LEVEL_MAX : quo_nxt[VAL_W-1:0];
  end

  // Request capture
  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      mode_r  <= mode_t'(in_mode);
      value_r <= in_value;
      index_r <= in_index;
    end
  end

  // Brightness state and cap table
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      applied_r <= '0;
      shown_r   <= '0;
      ureq_r    <= '0;
      step_r    <= '0;
      for (int i = 0; i < STEP_COUNT; i++) cap_r[i] <= CAP_RESET;
    end else if (cmd.exec) begin
      applied_r <= applied_nxt;
      shown_r   <= shown_nxt;
      ureq_r    <= ureq_nxt;
      step_r    <= step_nxt;
      if (cap_wr) cap_r[index_r[AW-1:0]] <= value_r;
    end
  end

  // Result flags, scaling and divider
  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      res_valid_r <= fire;
      res_up_r    <= fire && (applied_r == '0);
      res_down_r  <= fire && (lvl == '0);
      res_drive_r <= (fire && !scale_en) ? lvl : '0;
      status_r    <= status_nxt;
      lvl_r       <= lvl;
    end
    if (cmd.mul) begin
      rem_r <= '0;
      quo_r <= lvl_r * cfg.limit_level;
      den_r <= (cfg.full_scale != '0) ? cfg.full_scale : VAL_W'(1);
      cnt_r <= '0;
    end
    if (cmd.div_step) begin
      rem_r <= ge ? diff[VAL_W-1:0] : shifted[VAL_W-1:0];
      quo_r <= quo_nxt;
      cnt_r <= cnt_r + 1'b1;
      if (stat.div_last) res_drive_r <= res_drive_nxt;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_data_r <= {status_r, step_r, shown_r, res_down_r, res_up_r,
                     res_drive_r, res_valid_r};
    end
  end

  assign out_data = out_data_r;

endmodule

`default_nettype wire

// ----- rtl/thermal_capped_backlight_control_top.sv -----
// Top level of the thermal-capped backlight controller.
// Depends on tcbc_pkg, tcbc_cfg, tcbc_ctrl and tcbc_dp.
//
//  Channel | Ports                          | Payload
//  --------+--------------------------------+------------------------------------
//  in      | in_tvalid/in_tready/tdata/tuser| tuser: mode; tdata: value, index
//  out     | out_tvalid/out_tready/out_tdata| drive flags/value, brightness, step
//  cfg     | psel/penable/pwrite/paddr/...  | pwm_select, limit, full_scale, top
//
// One request at a time: an accepted request passes the execute and done
// states, and when the drive level is scaled also the 8x8 multiply state and
// a serial divider producing one quotient bit per cycle.
// Reset is synchronous; it restores the cap table to 175.
// A held result in the output register does not block acceptance of the
// next request; only a second finished result waits for out_tready.
`default_nettype none

module thermal_capped_backlight_control_top
  import tcbc_pkg::*;
#(
  parameter int STEP_COUNT = STEP_COUNT_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  // Request stream
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  input  wire logic [IN_DATA_W-1:0]  in_tdata,   // value[7:0], index[11:8], zero pad
  input  wire logic [MODE_W-1:0]     in_tuser,   // mode[1:0]
  // Result stream
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  output logic      [OUT_DATA_W-1:0] out_tdata,  // drive_valid[0], drive_value[8:1],
                                                 // power_up[9], power_down[10],
                                                 // reported_brightness[18:11],
                                                 // active_step[22:19], status[23]
  // Configuration
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [CFG_ADDR_W-1:0] paddr,
  input  wire logic [31:0]           pwdata,
  output logic      [31:0]           prdata,
  output logic                       pready
);

  cfg_t  cfg;
  cmd_t  cmd;
  stat_t stat;

  tcbc_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  tcbc_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .stat       (stat),
    .cmd        (cmd)
  );

  tcbc_dp #(
    .STEP_COUNT (STEP_COUNT)
  ) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg),
    .in_mode  (in_tuser),
    .in_value (in_tdata[VAL_W-1:0]),
    .in_index (in_tdata[VAL_W+STEP_W-1:VAL_W]),
    .cmd      (cmd),
    .stat     (stat),
    .out_data (out_tdata)
  );

  // One request in flight: no accept right after an accept
  a_single_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("request accepted while another is in flight");

  // Power-up and power-down never flagged together
  a_power_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !(out_tdata[9] && out_tdata[10]))
    else $error("power_up and power_down both set");

  // No drive value or power flags without a drive update
  a_drive_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tdata[0] |-> (out_tdata[10:1] == '0))
    else $error("drive fields set without drive_valid");

  // Reported step never beyond the table depth
  a_step_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[22:19] <= STEP_W'(STEP_COUNT)))
    else $error("active_step beyond table depth");

endmodule

`default_nettype wire

// ----- tb/tcbc_drive_checker.sv -----
`timescale 1ns / 100ps
// Result checker for the thermal-capped backlight controller testbench.
// Watches the request, result and register channels, predicts each result itself
// and compares it with what the block returns. Depends on tcbc_pkg only.

module tcbc_drive_checker
  import tcbc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  input  logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,   // value[7:0], index[11:8], zero pad
  input  logic [MODE_W-1:0]     in_tuser,   // mode[1:0]
  input  logic                  out_tvalid,
  input  logic                  out_tready,
  input  logic [OUT_DATA_W-1:0] out_tdata,  // drive_valid[0], drive_value[8:1],
                                            // power_up[9], power_down[10],
                                            // reported_brightness[18:11],
                                            // active_step[22:19], status[23]
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic                  pready,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [31:0]           pwdata,
  output int                    fail_count,
  output int                    outstanding
);

  localparam int STEPS = STEP_COUNT_DEF;

  // Declared from the top bit down so it lines up with out_tdata
  typedef struct packed {
    logic              status;
    logic [STEP_W-1:0] active_step;
    logic [VAL_W-1:0]  brightness;
    logic              power_down;
    logic              power_up;
    logic [VAL_W-1:0]  drive_value;
    logic              drive_valid;
  } drive_result_t;

  // Shadow registers
  logic              sh_pwm_select;
  logic [VAL_W-1:0]  sh_limit_level;
  logic [VAL_W-1:0]  sh_full_scale;
  logic [STEP_W-1:0] sh_top_step;

  // Shadow controller state
  logic [VAL_W-1:0]  applied_level;
  logic [VAL_W-1:0]  shown_level;
  logic [VAL_W-1:0]  user_level;
  logic [STEP_W-1:0] thermal_step;
  logic [VAL_W-1:0]  cap_level [STEPS];

  drive_result_t expected_q [$];
  drive_result_t next_result;
  int            reported;

  // Drive value for a brightness, with optional limit/full_scale scaling
  function automatic logic [VAL_W-1:0] scaled_drive(input logic [VAL_W-1:0] level);
    int unsigned den;
    int unsigned quot;
    if (sh_pwm_select || sh_limit_level == 0) return level;
    den  = (sh_full_scale == 0) ? 1 : int'(sh_full_scale);
    quot = (int'(level) * int'(sh_limit_level)) / den;
    return (quot > 255) ? LEVEL_MAX : quot[VAL_W-1:0];
  endfunction

  // Apply a brightness: drive on any change, flag zero transitions
  task automatic apply_level(input logic [VAL_W-1:0] level);
    if (applied_level == 0 && level != 0) next_result.power_up = 1'b1;
    else if (applied_level == level) return;
    next_result.drive_valid = 1'b1;
    next_result.drive_value = scaled_drive(level);
    if (applied_level != 0 && level == 0) next_result.power_down = 1'b1;
    applied_level = level;
    shown_level   = level;
  endtask

  // Expected result of one accepted request
  task automatic predict_drive_result(input mode_t mode, input logic [VAL_W-1:0] value,
                                      input logic [STEP_W-1:0] idx);
    logic [STEP_W-1:0] top;
    logic [STEP_W-1:0] clamped;
    next_result = '0;
    case (mode)
      MODE_USER: begin
        user_level = value;
        if (thermal_step != 0 && thermal_step <= STEPS &&
            value > cap_level[thermal_step-1])
          shown_level = cap_level[thermal_step-1];
        else
          apply_level(value);
      end
      MODE_STEP: begin
        if (thermal_step == 0) user_level = applied_level;
        if (thermal_step != idx) begin
          top     = (sh_top_step > STEPS) ? STEPS[STEP_W-1:0] : sh_top_step;
          clamped = (idx > top) ? top : idx;
          thermal_step = clamped;
          if (clamped == 0) apply_level(user_level);
          else if (cap_level[clamped-1] <= user_level) apply_level(cap_level[clamped-1]);
        end
      end
      MODE_CAP: begin
        if (idx >= STEPS) next_result.status = 1'b1;
        else cap_level[idx] = value;
      end
      default: ;  // query changes nothing
    endcase
    next_result.brightness  = shown_level;
    next_result.active_step = thermal_step;
    expected_q.push_back(next_result);
  endtask

  // Compare one returned result with the oldest expectation
  task automatic check_result(input drive_result_t got);
    drive_result_t want;
    if (expected_q.size() == 0) begin
      fail_count++;
      if (reported < 10) begin
        reported++;
        $display("%0t: result with no request pending: %h", $realtime, got);
      end
      return;
    end
    want = expected_q.pop_front();
    if (got.drive_valid !== want.drive_valid || got.drive_value !== want.drive_value ||
        got.power_up !== want.power_up || got.power_down !== want.power_down ||
        got.brightness !== want.brightness || got.active_step !== want.active_step ||
        got.status !== want.status) begin
      fail_count++;
      if (reported < 10) begin
        reported++;
        $display("%0t: mismatch exp valid=%0d drive=%0d up=%0d down=%0d bright=%0d step=%0d st=%0d",
                 $realtime, want.drive_valid, want.drive_value, want.power_up,
                 want.power_down, want.brightness, want.active_step, want.status);
        $display("%0t:          got valid=%0d drive=%0d up=%0d down=%0d bright=%0d step=%0d st=%0d",
                 $realtime, got.drive_valid, got.drive_value, got.power_up,
                 got.power_down, got.brightness, got.active_step, got.status);
      end
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      sh_pwm_select  = 1'b0;
      sh_limit_level = '0;
      sh_full_scale  = FULL_RESET;
      sh_top_step    = TOP_RESET;
      applied_level  = '0;
      shown_level    = '0;
      user_level     = '0;
      thermal_step   = '0;
      for (int i = 0; i < STEPS; i++) cap_level[i] = CAP_RESET;
      expected_q.delete();
      fail_count = 0;
      reported   = 0;
    end else begin
      // Register writes
      if (psel && penable && pwrite && pready) begin
        case (reg_idx_t'(paddr[3:2]))
          REG_PWM_SELECT:  sh_pwm_select  = pwdata[0];
          REG_LIMIT_LEVEL: sh_limit_level = pwdata[VAL_W-1:0];
          REG_FULL_SCALE:  sh_full_scale  = pwdata[VAL_W-1:0];
          REG_TOP_STEP:    sh_top_step    = pwdata[STEP_W-1:0];
          default: ;
        endcase
      end
      if (in_tvalid && in_tready)
        predict_drive_result(mode_t'(in_tuser), in_tdata[7:0], in_tdata[11:8]);
      if (out_tvalid && out_tready)
        check_result(out_tdata);
    end
    outstanding <= expected_q.size();
  end

endmodule

// ----- tb/tb_thermal_capped_backlight_control_top.sv -----
`timescale 1ns / 100ps
// Testbench top for thermal_capped_backlight_control_top: clock, reset, request and
// register stimulus, random output stalls and the verdict. Depends on tcbc_pkg,
// tcbc_drive_checker and the RTL.

module tb_thermal_capped_backlight_control_top;
  import tcbc_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int SETTLE_CYCLES  = 30;
  localparam int RANDOM_PHASES  = 5;
  localparam int PHASE_ITEMS    = 100;

  logic                  clk;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata;   // value[7:0], index[11:8], zero pad
  logic [MODE_W-1:0]     in_tuser;   // mode[1:0]
  logic                  out_tvalid;
  logic                  out_tready;
  logic [OUT_DATA_W-1:0] out_tdata;  // drive_valid[0], drive_value[8:1], power_up[9],
                                     // power_down[10], reported_brightness[18:11],
                                     // active_step[22:19], status[23]
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [CFG_ADDR_W-1:0] paddr;
  logic [31:0]           pwdata;
  logic [31:0]           prdata;
  logic                  pready;

  int fail_count;
  int outstanding;
  int idle_cycles;
  int tx_calm;
  int rx_stall;
  int rx_calm;
  int rx_roll;

  thermal_capped_backlight_control_top u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  tcbc_drive_checker u_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .pready      (pready),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .fail_count  (fail_count),
    .outstanding (outstanding)
  );

  // Clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Result side: short stalls often, long ones rarely, calm stretches now and then
  always @(negedge clk) begin
    if (rx_stall > 0) begin
      rx_stall = rx_stall - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
      if (rx_calm > 0) rx_calm = rx_calm - 1;
      else begin
        rx_roll = $urandom_range(0, 999);
        if (rx_roll < 5) rx_calm = $urandom_range(50, 200);
        else if (rx_roll < 25) rx_stall = $urandom_range(20, 60);
        else if (rx_roll < 300) rx_stall = $urandom_range(1, 4);
      end
    end
  end

  // Watchdog: cycles without any accepted transfer
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) ||
        (psel && penable && pready))
      idle_cycles <= 0;
    else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("[thermal_capped_backlight_control_top] ERROR");
      $finish;
    end else
      idle_cycles <= idle_cycles + 1;
  end

  // Gap before a request: mostly none, a few long
  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 88) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Register value biased to the extremes
  function automatic logic [7:0] pick_level();
    int roll;
    roll = $urandom_range(0, 9);
    if (roll < 2) return 8'd0;
    if (roll < 3) return 8'd1;
    if (roll < 5) return 8'd255;
    return 8'($urandom_range(0, 255));
  endfunction

  // Present one request and hold it until accepted
  task automatic send_request(input mode_t mode, input logic [7:0] value,
                              input logic [3:0] idx);
    int gap;
    if (tx_calm > 0) begin
      tx_calm--;
      gap = 0;
    end else begin
      gap = pick_gap();
      if ($urandom_range(0, 199) == 0) tx_calm = $urandom_range(30, 100);
    end
    repeat (gap) begin
      @(negedge clk);
      in_tvalid <= 1'b0;
    end
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tdata  <= {4'b0000, idx, value};
    in_tuser  <= mode;
    do @(posedge clk); while (!in_tready);
  endtask

  // Register write: setup cycle then access cycle
  task automatic write_reg(input reg_idx_t idx, input logic [31:0] data);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= data;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Drop valid and wait until every request has its result
  task automatic settle();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (outstanding != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Random request; values lean toward zero, full scale and the reset cap
  task automatic random_request();
    int          roll;
    mode_t       mode;
    logic [7:0]  value;
    logic [3:0]  idx;
    roll = $urandom_range(0, 99);
    if (roll < 35) mode = MODE_USER;
    else if (roll < 65) mode = MODE_STEP;
    else if (roll < 85) mode = MODE_CAP;
    else mode = MODE_QUERY;
    roll = $urandom_range(0, 99);
    if (roll < 12) value = 8'd0;
    else if (roll < 24) value = 8'd255;
    else if (roll < 36) value = 8'($urandom_range(170, 180));
    else value = 8'($urandom_range(0, 255));
    roll = $urandom_range(0, 99);
    case (mode)
      MODE_STEP: idx = (roll < 20) ? 4'd0 :
                       (roll < 85) ? 4'($urandom_range(1, 12)) : 4'($urandom_range(13, 15));
      MODE_CAP:  idx = (roll < 85) ? 4'($urandom_range(0, 11)) : 4'($urandom_range(12, 15));
      default:   idx = 4'($urandom_range(0, 15));
    endcase
    send_request(mode, value, idx);
  endtask

  initial begin
    clk        = 1'b0;
    rst_n      = 1'b0;
    in_tvalid  = 1'b0;
    in_tdata   = '0;
    in_tuser   = MODE_QUERY;
    out_tready = 1'b0;
    psel       = 1'b0;
    penable    = 1'b0;
    pwrite     = 1'b0;
    paddr      = '0;
    pwdata     = '0;
    tx_calm    = 0;
    rx_stall   = 0;
    rx_calm    = 0;
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;

    // Directed: reset state, zero transitions, unchanged level, throttling
    send_request(MODE_QUERY, 8'd0,   4'd0);
    send_request(MODE_USER,  8'd0,   4'd0);
    send_request(MODE_USER,  8'd255, 4'd15);
    send_request(MODE_USER,  8'd255, 4'd0);
    send_request(MODE_USER,  8'd0,   4'd0);
    send_request(MODE_USER,  8'd100, 4'd0);
    send_request(MODE_STEP,  8'd0,   4'd3);   // step entry, cap above request
    send_request(MODE_STEP,  8'd0,   4'd3);   // same step
    send_request(MODE_USER,  8'd200, 4'd0);   // above cap: only recorded
    send_request(MODE_CAP,   8'd50,  4'd2);
    send_request(MODE_CAP,   8'd255, 4'd12);  // rejected index
    send_request(MODE_CAP,   8'd0,   4'd15);  // rejected index
    send_request(MODE_STEP,  8'd0,   4'd15);  // clamped to top step
    send_request(MODE_STEP,  8'd0,   4'd3);
    send_request(MODE_STEP,  8'd0,   4'd0);   // leave throttling
    send_request(MODE_CAP,   8'd0,   4'd0);
    send_request(MODE_STEP,  8'd0,   4'd1);   // cap of zero powers down
    send_request(MODE_USER,  8'd0,   4'd0);
    send_request(MODE_STEP,  8'd0,   4'd0);
    settle();

    // Scaling by a limit of 255 over a zero full scale, top step of zero
    write_reg(REG_LIMIT_LEVEL, 32'd255);
    write_reg(REG_FULL_SCALE,  32'd0);
    write_reg(REG_PWM_SELECT,  32'd0);
    write_reg(REG_TOP_STEP,    32'd0);
    send_request(MODE_USER, 8'd1, 4'd0);
    send_request(MODE_STEP, 8'd0, 4'd7);
    settle();

    // Unscaled pwm drive, top step past the table
    write_reg(REG_LIMIT_LEVEL, 32'd128);
    write_reg(REG_FULL_SCALE,  32'd255);
    write_reg(REG_PWM_SELECT,  32'd1);
    write_reg(REG_TOP_STEP,    32'd15);
    send_request(MODE_USER, 8'd200, 4'd0);
    send_request(MODE_STEP, 8'd0,   4'd14);
    settle();
    write_reg(REG_PWM_SELECT, 32'd0);
    send_request(MODE_STEP,  8'd0, 4'd0);
    send_request(MODE_QUERY, 8'd0, 4'd0);
    settle();

    // Random phases, each under its own register setting
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      write_reg(REG_PWM_SELECT,  {$urandom} & 32'hFFFF_FFFE | 32'($urandom_range(0, 1)));
      write_reg(REG_LIMIT_LEVEL, {$urandom} & 32'hFFFF_FF00 | 32'(pick_level()));
      write_reg(REG_FULL_SCALE,  {$urandom} & 32'hFFFF_FF00 | 32'(pick_level()));
      write_reg(REG_TOP_STEP,    {$urandom} & 32'hFFFF_FFF0 | 32'($urandom_range(0, 15)));
      repeat (PHASE_ITEMS) random_request();
      settle();
    end

    if (fail_count == 0 && outstanding == 0)
      $display("[thermal_capped_backlight_control_top] OK");
    else
      $display("[thermal_capped_backlight_control_top] ERROR");
    $finish;
  end

endmodule
